/* rtl/linear_to_tformat_tile_address_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the linear-to-tiled address unit
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LINEAR_TO_TFORMAT_TILE_ADDRESS_UNIT_MACROS_SVH
`define LINEAR_TO_TFORMAT_TILE_ADDRESS_UNIT_MACROS_SVH

// Same-cycle implication.
`define LTT_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ltt assertion failed");

// Next-cycle implication.
`define LTT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ltt assertion failed");

`endif

/* rtl/ltt_pkg.sv */
// ---------------------------------------------------------------------------
// ltt_pkg
// Types and constants of the linear-to-tiled address unit.
// ---------------------------------------------------------------------------
package ltt_pkg;

    localparam int COL_W    = 8;
    localparam int ROW_W    = 8;
    localparam int PIXEL_W  = 32;
    localparam int OFFSET_W = 16;
    localparam int BANDS_W  = 3;
    localparam int BAND_POS_W = 2;

    // Largest meaningful band count: 256 rows fill the offset space.
    localparam logic [BANDS_W-1:0] MAX_BANDS   = 3'd4;
    localparam logic [BANDS_W-1:0] RESET_BANDS = 3'd4;

    // Control bits that travel with each pipeline stage.
    typedef struct packed {
        logic valid;
        logic oor;
    } ltt_ctrl_t;

endpackage

/* rtl/ltt_tile_map.sv */
// ---------------------------------------------------------------------------
// ltt_tile_map
// Maps band position, column and row to the tiled word offset.
// ---------------------------------------------------------------------------
module ltt_tile_map
    import ltt_pkg::*;
(
    input  logic [BAND_POS_W-1:0] band_pos,
    input  logic [COL_W-1:0]      column,
    input  logic [5:0]            row,        // row within its band
    output logic [OFFSET_W-1:0]   word_offset
);

    logic       upper;
    logic [2:0] tile_field;
    logic [1:0] sel;
    logic [1:0] sub;

    assign upper = row[5];
    assign sel   = {column[4], row[4]};

    // Lower half runs right to left.
    assign tile_field = upper ? column[7:5] : ~column[7:5];

    always_comb
    begin
        sub = 2'd0;
        if (upper)
        begin
            case (sel)
                2'd0:    sub = 2'd1;
                2'd1:    sub = 2'd0;
                2'd2:    sub = 2'd2;
                2'd3:    sub = 2'd3;
                default: sub = 2'd0;
            endcase
        end
        else
        begin
            case (sel)
                2'd0:    sub = 2'd3;
                2'd1:    sub = 2'd2;
                2'd2:    sub = 2'd0;
                2'd3:    sub = 2'd1;
                default: sub = 2'd0;
            endcase
        end
    end

    // band | half | tile | subtile | microtile row,col | pixel row,col
    assign word_offset = {band_pos, ~upper, tile_field, sub,
                          ~row[3:2], column[3:2], ~row[1:0], column[1:0]};

endmodule

/* rtl/linear_to_tformat_tile_address_unit.sv */
// ---------------------------------------------------------------------------
// linear_to_tformat_tile_address_unit
// Linear 256-wide image pixel to tiled texture word offset.
// ---------------------------------------------------------------------------
// Path: an accepted start passes the stage 1, 2 and 3 registers to the done strobe.
// Throughput: one transaction per cycle; busy is held low, the pipeline
//   never stalls because the receiver cannot hold results off.
// Reset: rst_n clears all valid bits and sets band_count to 4.
// ---------------------------------------------------------------------------
module linear_to_tformat_tile_address_unit
    import ltt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                band_count_wr_en,
    input  logic [BANDS_W-1:0]  band_count_wdata,
    // input transaction
    input  logic                start,
    output logic                busy,
    input  logic [COL_W-1:0]    column,
    input  logic [ROW_W-1:0]    row,
    input  logic [PIXEL_W-1:0]  pixel_in,
    // result transaction
    output logic                done,
    output logic [OFFSET_W-1:0] word_offset,
    output logic [PIXEL_W-1:0]  pixel_out,
    output logic                row_out_of_range
);

`include "linear_to_tformat_tile_address_unit_macros.svh"

    logic [BANDS_W-1:0] band_count_reg;
    logic [BANDS_W-1:0] band_count_next;
    logic [BANDS_W-1:0] bands_clamped;

    // Stage 1: range check and band position.
    ltt_ctrl_t              s1_ctrl_reg,  s1_ctrl_next;
    logic [BAND_POS_W-1:0]  s1_band_pos_reg, s1_band_pos_next;
    logic [COL_W-1:0]       s1_col_reg;
    logic [5:0]             s1_row_reg;     // row within its band
    logic [PIXEL_W-1:0]     s1_pixel_reg;

    // Stage 2: tiled offset.
    ltt_ctrl_t              s2_ctrl_reg;
    logic [OFFSET_W-1:0]    s2_offset_reg, s2_offset_next;
    logic [PIXEL_W-1:0]     s2_pixel_reg;

    // Stage 3: output register.
    ltt_ctrl_t              s3_ctrl_reg;
    logic [OFFSET_W-1:0]    s3_offset_reg, s3_offset_next;
    logic [PIXEL_W-1:0]     s3_pixel_reg;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration register; the user must write it only while the pipeline is empty, the block does not enforce this.
    assign band_count_next = band_count_wr_en ? band_count_wdata : band_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            band_count_reg <= RESET_BANDS;
        else
            band_count_reg <= band_count_next;
    end

    // Counts above four behave as four; zero flags every row.
    assign bands_clamped = (band_count_reg > MAX_BANDS) ? MAX_BANDS : band_count_reg;

    always_comb
    begin
        s1_ctrl_next.valid = accept;
        s1_ctrl_next.oor   = ({1'b0, row[7:6]} >= bands_clamped);
        // Top band first: position = bands - 1 - row band, modulo 4.
        s1_band_pos_next   = bands_clamped[BAND_POS_W-1:0] - 2'd1 - row[7:6];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_ctrl_reg <= s2_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_band_pos_reg <= s1_band_pos_next;
        s1_col_reg      <= column;
        s1_row_reg      <= row[5:0];
        s1_pixel_reg    <= pixel_in;
        s2_offset_reg   <= s2_offset_next;
        s2_pixel_reg    <= s1_pixel_reg;
        s3_offset_reg   <= s3_offset_next;
        s3_pixel_reg    <= s2_pixel_reg;
    end

    ltt_tile_map u_tile_map (
        .band_pos    (s1_band_pos_reg),
        .column      (s1_col_reg),
        .row         (s1_row_reg),
        .word_offset (s2_offset_next)
    );

    // Out-of-range rows report a zero offset.
    assign s3_offset_next = s2_ctrl_reg.oor ? '0 : s2_offset_reg;

    assign done             = s3_ctrl_reg.valid;
    assign row_out_of_range = s3_ctrl_reg.oor;
    assign word_offset      = s3_offset_reg;
    assign pixel_out        = s3_pixel_reg;

    `LTT_ASSERT_NEXT(a_start_enters, start, s1_ctrl_reg.valid)
    `LTT_ASSERT_IMPL(a_latency, start, ##3 done)
    `LTT_ASSERT_IMPL(a_oor_zero, done && row_out_of_range, word_offset == '0)
    `LTT_ASSERT_IMPL(a_pixel_bits, done && !row_out_of_range,
        word_offset[3:0] == {~$past(row[1:0], 3), $past(column[1:0], 3)})

endmodule

/* bench/linear_to_tformat_tile_address_unit_test.sv */
// ----------------------------------------------------------------------------
// Linear-to-tiled address unit testbench
// Feeds pixels with their column and row, predicts each tiled word offset,
// pass-through pixel and out-of-range flag, and checks every done strobe
// against the oldest prediction. The band count is changed between phases.
// ----------------------------------------------------------------------------
module linear_to_tformat_tile_address_unit_test;

    import ltt_pkg::*;

    // Cycles with no transaction on either side before the run is abandoned.
    localparam int STALL_LIMIT = 1000;
    // Extra cycles after the last result, well beyond the pipeline depth.
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_PER_PHASE = 65;

    // Subtile slot inside a tile, indexed by {right half, top half}.
    localparam logic [1:0] UPPER_SLOT [4] = '{2'd1, 2'd0, 2'd2, 2'd3};
    localparam logic [1:0] LOWER_SLOT [4] = '{2'd3, 2'd2, 2'd0, 2'd1};

    typedef enum logic [1:0] {
        FEED_PIXEL,
        FEED_SET_BANDS,
        FEED_DRAIN
    } feed_kind_t;

    typedef struct {
        feed_kind_t           kind;
        logic                 calm;     // never idle in front of this pixel
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        logic [PIXEL_W-1:0]   pixel;
        logic [BANDS_W-1:0]   bands;
    } feed_entry_t;

    typedef struct {
        logic [OFFSET_W-1:0]  offset;
        logic [PIXEL_W-1:0]   pixel;
        logic                 oor;
    } tiled_pixel_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                band_count_wr_en = 1'b0;
    logic [BANDS_W-1:0]  band_count_wdata = '0;
    logic                start = 1'b0;
    logic                busy;
    logic [COL_W-1:0]    column = '0;
    logic [ROW_W-1:0]    row = '0;
    logic [PIXEL_W-1:0]  pixel_in = '0;
    logic                done;
    logic [OFFSET_W-1:0] word_offset;
    logic [PIXEL_W-1:0]  pixel_out;
    logic                row_out_of_range;

    feed_entry_t         pixel_feed[$];
    tiled_pixel_t        pending_tiled_pixels[$];

    // Band count as the block holds it, tracked on every register write.
    logic [BANDS_W-1:0]  bands_now = RESET_BANDS;
    int                  n_accepted = 0;
    int                  n_results = 0;
    int                  n_errors = 0;
    int                  quiet_cycles = 0;

    linear_to_tformat_tile_address_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .band_count_wr_en (band_count_wr_en),
        .band_count_wdata (band_count_wdata),
        .start            (start),
        .busy             (busy),
        .column           (column),
        .row              (row),
        .pixel_in         (pixel_in),
        .done             (done),
        .word_offset      (word_offset),
        .pixel_out        (pixel_out),
        .row_out_of_range (row_out_of_range)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: the offset is a plain bit concatenation of
    //   {tile position (6), subtile slot (2), microtile (4), pixel (4)}.
    // Upper half tiles run left to right, lower half tiles right to left,
    // and rows inside microtiles and subtiles run from the top down,
    // which inverts the two-bit row fields.
    // ------------------------------------------------------------------------
    function automatic tiled_pixel_t map_to_tiled(
        input logic [COL_W-1:0]   col,
        input logic [ROW_W-1:0]   r,
        input logic [PIXEL_W-1:0] pixel,
        input logic [BANDS_W-1:0] bands_reg
    );
        logic [BANDS_W-1:0] bands;
        logic [BANDS_W-1:0] band_from_top;
        logic [5:0]         tile_pos;
        logic [1:0]         sel;
        logic [1:0]         slot;
        tiled_pixel_t       res;

        // Anything above four bands is clamped; zero bands flags every row.
        bands = (bands_reg > MAX_BANDS) ? MAX_BANDS : bands_reg;
        band_from_top = bands - 3'd1 - {1'b0, r[7:6]};
        sel = {col[4], r[4]};
        if (r[5])
        begin
            tile_pos = {band_from_top[1:0], 1'b0, col[7:5]};
            slot = UPPER_SLOT[sel];
        end
        else
        begin
            tile_pos = {band_from_top[1:0], 1'b1, ~col[7:5]};
            slot = LOWER_SLOT[sel];
        end
        res.pixel = pixel;
        res.oor = ({1'b0, r} >= {bands, 6'd0});
        res.offset = res.oor ? '0
                   : {tile_pos, slot, ~r[3:2], col[3:2], ~r[1:0], col[1:0]};
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one feed entry at a time. A band count write or a drain point
    // waits until every accepted transaction has produced its result, so the
    // register only changes with the pipeline empty.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic next_start;
        logic next_wr;
        logic drained;

        if (!rst_n)
        begin
            start <= 1'b0;
            band_count_wr_en <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                pending_tiled_pixels.push_back(
                    map_to_tiled(column, row, pixel_in, bands_now));
                n_accepted = n_accepted + 1;
            end
            drained = (n_accepted == n_results);
            next_start = 1'b0;
            next_wr = 1'b0;
            if (start && busy)
            begin
                // Refused: hold the same transaction.
                next_start = 1'b1;
            end
            else if (pixel_feed.size() > 0)
            begin
                case (pixel_feed[0].kind)
                    FEED_PIXEL:
                    begin
                        if (pixel_feed[0].calm || $urandom_range(99) >= 30)
                        begin
                            column <= pixel_feed[0].col;
                            row <= pixel_feed[0].row;
                            pixel_in <= pixel_feed[0].pixel;
                            next_start = 1'b1;
                            void'(pixel_feed.pop_front());
                        end
                    end
                    FEED_SET_BANDS:
                    begin
                        if (drained)
                        begin
                            band_count_wdata <= pixel_feed[0].bands;
                            bands_now = pixel_feed[0].bands;
                            next_wr = 1'b1;
                            void'(pixel_feed.pop_front());
                        end
                    end
                    FEED_DRAIN:
                    begin
                        if (drained)
                            void'(pixel_feed.pop_front());
                    end
                    default:
                        void'(pixel_feed.pop_front());
                endcase
            end
            start <= next_start;
            band_count_wr_en <= next_wr;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every done strobe is one result transaction, taken in order.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        tiled_pixel_t want;

        if (rst_n && done)
        begin
            if (pending_tiled_pixels.size() == 0)
            begin
                $display("%0t: result with none expected: offset %h pixel %h oor %b",
                         $time, word_offset, pixel_out, row_out_of_range);
                n_errors = n_errors + 1;
            end
            else
            begin
                want = pending_tiled_pixels.pop_front();
                if (word_offset !== want.offset)
                begin
                    $display("%0t: word_offset expected %h actual %h",
                             $time, want.offset, word_offset);
                    n_errors = n_errors + 1;
                end
                if (pixel_out !== want.pixel)
                begin
                    $display("%0t: pixel_out expected %h actual %h",
                             $time, want.pixel, pixel_out);
                    n_errors = n_errors + 1;
                end
                if (row_out_of_range !== want.oor)
                begin
                    $display("%0t: row_out_of_range expected %b actual %b",
                             $time, want.oor, row_out_of_range);
                    n_errors = n_errors + 1;
                end
            end
            n_results <= n_results + 1;
        end
    end

    // Watchdog: counts cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] r,
                              input logic [PIXEL_W-1:0] pixel, input logic calm);
        feed_entry_t e;
        e = '{FEED_PIXEL, calm, col, r, pixel, '0};
        pixel_feed.push_back(e);
    endtask

    task automatic push_control(input feed_kind_t kind, input logic [BANDS_W-1:0] bands);
        feed_entry_t e;
        e = '{kind, 1'b0, '0, '0, '0, bands};
        pixel_feed.push_back(e);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        logic [BANDS_W-1:0] phase_bands [10];
        logic [ROW_W-1:0]   r;
        int                 n_random;

        phase_bands = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd6, 3'd4, 3'd2, 3'd1};
        n_random = 0;

        // Directed, with the reset band count of four: corners, pixel
        // extremes, each subtile of an upper and of a lower tile, band edges.
        push_pixel(8'd0,   8'd0,   32'h0000_0000, 1'b0);
        push_pixel(8'd255, 8'd255, 32'hFFFF_FFFF, 1'b0);
        push_pixel(8'd0,   8'd255, 32'hA5A5_A5A5, 1'b0);
        push_pixel(8'd255, 8'd0,   32'h5A5A_5A5A, 1'b0);
        push_pixel(8'd0,   8'd63,  $urandom, 1'b0);   // upper, top-left
        push_pixel(8'd0,   8'd47,  $urandom, 1'b0);   // upper, bottom-left
        push_pixel(8'd20,  8'd40,  $urandom, 1'b0);   // upper, bottom-right
        push_pixel(8'd31,  8'd60,  $urandom, 1'b0);   // upper, top-right
        push_pixel(8'd17,  8'd5,   $urandom, 1'b0);   // lower, bottom-right
        push_pixel(8'd30,  8'd20,  $urandom, 1'b0);   // lower, top-right
        push_pixel(8'd3,   8'd25,  $urandom, 1'b0);   // lower, top-left
        push_pixel(8'd9,   8'd2,   $urandom, 1'b0);   // lower, bottom-left
        push_pixel(8'd128, 8'd64,  $urandom, 1'b0);
        push_pixel(8'd77,  8'd191, $urandom, 1'b0);
        push_pixel(8'd200, 8'd192, $urandom, 1'b0);
        // One band: last row in range, first row out of range.
        push_control(FEED_SET_BANDS, 3'd1);
        push_pixel(8'd100, 8'd63,  $urandom, 1'b0);
        push_pixel(8'd100, 8'd64,  $urandom, 1'b0);
        // Zero bands flags everything.
        push_control(FEED_SET_BANDS, 3'd0);
        push_pixel(8'd0,   8'd0,   $urandom, 1'b0);
        push_pixel(8'd255, 8'd255, $urandom, 1'b0);
        // Above four is clamped to four: the top row stays in range.
        push_control(FEED_SET_BANDS, 3'd7);
        push_pixel(8'd255, 8'd255, $urandom, 1'b0);
        push_pixel(8'd0,   8'd0,   $urandom, 1'b0);

        // Random phases, one band count each. A quarter of the rows sit
        // right around a band edge; a stretch in the middle runs back to back.
        foreach (phase_bands[p])
        begin
            push_control(FEED_SET_BANDS, phase_bands[p]);
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                if ($urandom_range(3) == 0)
                    r = {2'($urandom_range(3)), 6'd0} + 8'($urandom_range(3)) - 8'd2;
                else
                    r = 8'($urandom_range(255));
                push_pixel(8'($urandom_range(255)), r, $urandom,
                           (n_random >= 250 && n_random < 400));
                n_random++;
                if (k == RANDOM_PER_PHASE / 2 && p == 3)
                    push_control(FEED_DRAIN, '0);
                else if ($urandom_range(99) == 0)
                    push_control(FEED_DRAIN, '0);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pixel_feed.size() > 0 || start || n_accepted != n_results)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_tiled_pixels.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time,
                     pending_tiled_pixels.size());
            n_errors = n_errors + 1;
        end
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
